### rtl/packed_pixel_frame_store_defines.svh
// assertion macros used by the checker file
`ifndef PACKED_PIXEL_FRAME_STORE_DEFINES_SVH
`define PACKED_PIXEL_FRAME_STORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define PPFS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppfs port check failed");

// next-cycle implication, disabled while reset is high
`define PPFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppfs port check failed");

`endif

### rtl/ppfs_pkg.sv
`default_nettype none

package ppfs_pkg;

   // store geometry
   localparam int STORE_BYTES = 8192;
   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 128;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int LOC_W       = 16;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // request codes on the input channel
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_FILL  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;

   // pixel layouts
   localparam logic FMT_MONO = 1'b0;

   // work the back end carries out
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_FILL  = 2'd3
   } ppfs_op_type;

   typedef struct packed {
      ppfs_op_type       op;
      logic [ADDR_W-1:0] addr;
      logic              mono;
      logic [2:0]        lane;
      logic [3:0]        nib;
      logic              set;
   } ppfs_cmd_type;

endpackage

`default_nettype wire

### rtl/ppfs_front.sv
`default_nettype none

module ppfs_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  csr_we,
   input  wire  [1:0]           csr_index,
   input  wire  [7:0]           csr_wdata,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [31:0]          req_tdata,
   input  wire  [1:0]           req_tuser,
   input  wire                  push_ready,
   output logic                 push_valid,
   output ppfs_pkg::ppfs_cmd_type push_cmd
);
   import ppfs_pkg::*;

   logic       fmt_ff, fmt_in;
   logic [7:0] width_ff, width_in;
   logic [7:0] height_ff, height_in;

   logic [7:0]       pos_x, pos_y;
   logic [15:0]      color;
   logic [7:0]       w_eff, h_eff;
   logic [7:0]       mul_a, mul_b, offs;
   logic [LOC_W-1:0] prod, loc;
   logic             mono, on_screen, in_store, hit;

   // configuration registers
   always_comb begin
      fmt_in    = fmt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: fmt_in    = csr_wdata[0];
            CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default:          fmt_in    = fmt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_MONO;
         width_ff  <= 8'd128;
         height_ff <= 8'd64;
      end else begin
         fmt_ff    <= fmt_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // unpack request
   assign pos_x = req_tdata[7:0];
   assign pos_y = req_tdata[15:8];
   assign color = req_tdata[31:16];
   assign mono  = (fmt_ff == FMT_MONO);

   // geometry in effect and visibility
   assign w_eff     = (width_ff > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_ff;
   assign h_eff     = (height_ff > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : height_ff;
   assign on_screen = (pos_x < w_eff) && (pos_y < h_eff);

   // byte address: page * width + x in mono, row * (width / 2) + x / 2 in grey
   assign mul_a    = mono ? {3'b000, pos_y[7:3]} : pos_y;
   assign mul_b    = mono ? w_eff : {1'b0, w_eff[7:1]};
   assign offs     = mono ? pos_x : {1'b0, pos_x[7:1]};
   assign prod     = {8'd0, mul_a} * {8'd0, mul_b};
   assign loc      = prod + {8'd0, offs};
   assign in_store = ({1'b0, loc} < (LOC_W + 1)'(STORE_BYTES));
   assign hit      = on_screen && in_store;

   // classify into back-end work
   always_comb begin
      push_cmd.addr = loc[ADDR_W-1:0];
      push_cmd.mono = mono;
      push_cmd.lane = mono ? pos_y[2:0] : {2'b00, pos_x[0]};
      push_cmd.nib  = color[3:0];
      push_cmd.set  = |color;
      priority if (req_tuser == REQ_FILL)           push_cmd.op = OP_FILL;
      else if (req_tuser == REQ_WRITE && hit)      push_cmd.op = OP_WRITE;
      else if (req_tuser == REQ_READ && hit)       push_cmd.op = OP_READ;
      else                                          push_cmd.op = OP_NONE;
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid && push_ready;

endmodule

`default_nettype wire

### rtl/ppfs_queue.sv
`default_nettype none

module ppfs_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push_valid,
   input  ppfs_pkg::ppfs_cmd_type push_cmd,
   output logic                   push_ready,
   input  wire                    pop,
   output logic                   q_valid,
   output ppfs_pkg::ppfs_cmd_type q_cmd
);
   import ppfs_pkg::*;

   ppfs_cmd_type           slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_cmd      = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && q_valid;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/ppfs_back.sv
`default_nettype none

module ppfs_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_valid,
   input  ppfs_pkg::ppfs_cmd_type q_cmd,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [7:0]             rsp_tdata
);
   import ppfs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MERGE = 4'b0010,
      ST_READ  = 4'b0100,
      ST_FILL  = 4'b1000
   } ppfs_state_type;

   ppfs_state_type    state_ff, state_in;
   ppfs_cmd_type      cmd_ff, cmd_in;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        pix_ff, pix_in;

   logic [7:0]        frame_store_ff [STORE_BYTES];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   logic [7:0]        mem_wd;

   logic              out_free;
   logic [7:0]        bit_mask, merged;
   logic [3:0]        extracted;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // new byte for a pixel write, pixel from a read
   always_comb begin
      bit_mask = 8'd1 << cmd_ff.lane;
      if (cmd_ff.mono) begin
         merged    = cmd_ff.set ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
         extracted = {3'b000, rd_data_ff[cmd_ff.lane]};
      end else if (cmd_ff.lane[0]) begin
         merged    = {rd_data_ff[7:4], cmd_ff.nib};
         extracted = rd_data_ff[3:0];
      end else begin
         merged    = {cmd_ff.nib, rd_data_ff[3:0]};
         extracted = rd_data_ff[7:4];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pix_in       = pix_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = cmd_ff.addr;
      mem_wd       = merged;
      mem_ra       = q_cmd.addr;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.op)
                  OP_WRITE: state_in = ST_MERGE;
                  OP_READ:  state_in = ST_READ;
                  OP_FILL: begin
                     fill_in  = '0;
                     state_in = ST_FILL;
                  end
                  OP_NONE: begin
                     rsp_valid_in = 1'b1;
                     pix_in       = 4'd0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MERGE: begin
            mem_we       = 1'b1;
            rsp_valid_in = 1'b1;
            pix_in       = 4'd0;
            state_in     = ST_IDLE;
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            pix_in       = extracted;
            state_in     = ST_IDLE;
         end
         ST_FILL: begin
            mem_we  = 1'b1;
            mem_wa  = fill_ff;
            mem_wd  = {8{cmd_ff.set}};
            fill_in = fill_ff + 1'b1;
            if (fill_ff == ADDR_W'(STORE_BYTES - 1)) begin
               rsp_valid_in = 1'b1;
               pix_in       = 4'd0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      fill_ff <= fill_in;
      pix_ff  <= pix_in;
   end

   // frame store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_store_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= frame_store_ff[mem_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, pix_ff};

endmodule

`default_nettype wire

### rtl/packed_pixel_frame_store.sv
// Packed pixel frame store: an 8192-byte display memory in mono vertical-byte
// pages or 4-bit grey (two pixels a byte, odd x in the low nibble). Every
// request returns exactly one response; only reads of on-screen pixels give
// a nonzero value. A pixel write or read follows the registered read of the
// store: the byte is read as the command is popped, then merged and written
// back or the pixel picked out. A fill sweeps the store one byte a cycle.
// Off-screen and unused requests are answered from the idle state without a
// store access. Up to two classified requests wait in the queue while the
// back end is busy. The store holds no defined contents after reset until a
// fill or pixel write. The user must write the geometry registers only while
// no request is in flight; the block itself does not enforce this.
`default_nettype none

module packed_pixel_frame_store (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [7:0]  csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // pos_x [7:0], pos_y [15:8], color [31:16]
   input  wire  [1:0]  req_tuser,   // req_type [1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata    // pixel_value [3:0], zero [7:4]
);
   import ppfs_pkg::*;

   logic         push_valid, push_ready, q_valid, pop;
   ppfs_cmd_type push_cmd, q_cmd;

   ppfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   ppfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd)
   );

   ppfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### rtl/ppfs_checker.sv
`default_nettype none
`include "packed_pixel_frame_store_defines.svh"

module ppfs_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_tvalid,
   input wire       req_tready,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata
);

   logic [2:0] pending_ff, pending_in;
   logic       req_take, rsp_take, rsp_stall;

   // requests accepted but not yet answered
   assign req_take  = req_tvalid && req_tready;
   assign rsp_take  = rsp_tvalid && rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response holds its value
   `PPFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // no response without a request behind it
   `PPFS_ASSERT_NOW(a_no_extra_rsp, clock, reset, rsp_tvalid, pending_ff != 3'd0)
   // queue plus either the busy back end or the output register: at most three
   `PPFS_ASSERT_NOW(a_pending_bound, clock, reset, 1'b1, pending_ff <= 3'd3)
   // pixel values never reach the padding bits
   `PPFS_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[7:4] == 4'd0)

endmodule

bind packed_pixel_frame_store ppfs_checker u_ppfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
